/* rtl/bit_parallel_edit_distance_macros.svh */
// Assertion macros used by the edit distance top level.
`ifndef BIT_PARALLEL_EDIT_DISTANCE_MACROS_SVH
`define BIT_PARALLEL_EDIT_DISTANCE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset
`define BPED_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("bped assertion failed");

// Next-cycle implication, checked out of reset
`define BPED_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("bped assertion failed");

`else

`define BPED_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define BPED_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

/* rtl/bped_pkg.sv */
// Package: types and constants of the bit-parallel edit distance block.
`default_nettype none

package bped_pkg;

    // Default sizes
    localparam int QUERY_MAX_DEF     = 8;
    localparam int ALPHABET_SIZE_DEF = 26;

    // Field and register widths
    localparam int LETTER_W   = 5;
    localparam int QLET_W     = 40;
    localparam int QLEN_W     = 4;
    localparam int SCORE_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 40;

    // Query letter slots decoded per lane; slots beyond the letter register read as zero
    localparam int CODE_SLOTS = 12;
    localparam int QPAD_W     = CODE_SLOTS * LETTER_W;

    localparam logic [LETTER_W-1:0] NO_MATCH_CODE = 5'd31;
    localparam logic [SCORE_W-1:0]  SCORE_MAX     = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LETTERS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH  = 1'd1;

    // One input item
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                word_start;
        logic                word_end;
        logic                empty_word;
    } t_bped_item;

    // Score side of the running state
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [SCORE_W-1:0] count;
        logic               sat;
    } t_bped_score;

endpackage

`default_nettype wire

/* rtl/bped_step.sv */
// One letter step of the bit-vector edit distance recurrence, combinational.
`default_nettype none

module bped_step #(
    parameter int QUERY_MAX     = bped_pkg::QUERY_MAX_DEF,
    parameter int ALPHABET_SIZE = bped_pkg::ALPHABET_SIZE_DEF
) (
    input  wire bped_pkg::t_bped_item        i_item,
    input  wire logic [bped_pkg::QLET_W-1:0] i_qletters,
    input  wire logic [bped_pkg::QLEN_W-1:0] i_qlen,
    input  wire logic [QUERY_MAX-1:0]        i_vp,
    input  wire logic [QUERY_MAX-1:0]        i_vn,
    input  wire bped_pkg::t_bped_score       i_score,
    output logic [QUERY_MAX-1:0]             o_vp,
    output logic [QUERY_MAX-1:0]             o_vn,
    output bped_pkg::t_bped_score            o_score,
    output logic [bped_pkg::SCORE_W-1:0]     o_dist
);
    import bped_pkg::*;

    localparam int LW = $clog2(QUERY_MAX + 1);

    logic [6:0]           len_ext;
    logic [LW-1:0]        len_eff;
    logic [QPAD_W-1:0]    qpad;
    logic                 ch_ok;
    logic [QUERY_MAX-1:0] lane_en;
    logic [QUERY_MAX-1:0] lane_top;
    logic [QUERY_MAX-1:0] match;
    logic                 seed;
    logic [QUERY_MAX-1:0] s_vp;
    logic [QUERY_MAX-1:0] s_vn;
    t_bped_score          s_sc;
    logic [QUERY_MAX-1:0] x;
    logic [QUERY_MAX-1:0] sum;
    logic [QUERY_MAX-1:0] d0;
    logic [QUERY_MAX-1:0] hn;
    logic [QUERY_MAX-1:0] hp;
    logic [QUERY_MAX-1:0] y;
    logic                 top_hp;
    logic                 top_hn;
    logic [SCORE_W-1:0]   len_score;

    // Query length clipped to the vector width
    assign len_ext   = 7'(i_qlen);
    assign len_eff   = (len_ext > 7'(QUERY_MAX)) ? LW'(QUERY_MAX) : LW'(len_ext);
    assign len_score = SCORE_W'(len_eff);

    assign qpad  = QPAD_W'(i_qletters);
    assign ch_ok = (9'(i_item.letter) < 9'(ALPHABET_SIZE));

    // Per-lane match against the query, plus active and top-lane masks
    for (genvar j = 0; j < QUERY_MAX; j++) begin : g_lane
        logic [LETTER_W-1:0] code;
        if (j < CODE_SLOTS) begin : g_code
            assign code = qpad[j*LETTER_W +: LETTER_W];
        end else begin : g_none
            assign code = NO_MATCH_CODE;
        end
        assign lane_en[j]  = (int'(len_eff) > j);
        assign lane_top[j] = (int'(len_eff) == j + 1);
        assign match[j]    = lane_en[j] && ch_ok && (9'(code) < 9'(ALPHABET_SIZE))
                             && (code == i_item.letter);
    end

    // Reseed at a word start or an empty word
    assign seed = i_item.word_start || i_item.empty_word;
    always_comb begin
        if (seed) begin
            s_vp       = '1;
            s_vn       = '0;
            s_sc.score = len_score;
            s_sc.count = '0;
            s_sc.sat   = 1'b0;
        end else begin
            s_vp = i_vp;
            s_vn = i_vn;
            s_sc = i_score;
        end
    end

    // Vertical / horizontal delta recurrence
    assign x      = match | s_vn;
    assign sum    = (s_vp & x) + s_vp;
    assign d0     = (sum ^ s_vp) | x;
    assign hn     = s_vp & d0;
    assign hp     = s_vn | ~(s_vp | d0);
    assign y      = (hp << 1) | QUERY_MAX'(1);
    assign top_hp = |(hp & lane_top);
    assign top_hn = |(hn & lane_top);

    // Next state and score
    always_comb begin
        o_vp    = s_vp;
        o_vn    = s_vn;
        o_score = s_sc;
        if (!i_item.empty_word) begin
            if (s_sc.count != SCORE_MAX) begin
                o_score.count = s_sc.count + 1'b1;
            end
            if (len_eff != '0) begin
                o_vn = y & d0;
                o_vp = (hn << 1) | ~(y | d0);
                if (top_hp) begin
                    if (s_sc.sat || (s_sc.score == SCORE_MAX)) begin
                        o_score.sat   = 1'b1;
                        o_score.score = SCORE_MAX;
                    end else begin
                        o_score.score = s_sc.score + 1'b1;
                    end
                end else if (top_hn) begin
                    if (!s_sc.sat && (s_sc.score != '0)) begin
                        o_score.score = s_sc.score - 1'b1;
                    end
                end
            end
        end
    end

    // Distance reported on the last letter
    always_comb begin
        if (i_item.empty_word) begin
            o_dist = len_score;
        end else if (len_eff == '0) begin
            o_dist = o_score.count;
        end else begin
            o_dist = o_score.score;
        end
    end

endmodule

`default_nettype wire

/* rtl/bit_parallel_edit_distance.sv */
// Top level: streaming bit-parallel edit distance against a configured query.
// An accepted last letter is held in the input register, then its distance in the result register.
// Throughput: one letter per cycle unless stalled; the deltas update in one step per item.
// Reset (synchronous, active low): empties both stages, clears the query registers,
// seeds the deltas to all ones / zero and the score to zero.
`default_nettype none
`include "bit_parallel_edit_distance_macros.svh"

module bit_parallel_edit_distance #(
    parameter int QUERY_MAX     = bped_pkg::QUERY_MAX_DEF,
    parameter int ALPHABET_SIZE = bped_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Letter stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [7:0]                      i_s_axis_tdata,  // [4:0] letter, rest zero
    input  wire logic [1:0]                      i_s_axis_tuser,  // [0] word_start, [1] empty_word
    input  wire logic                            i_s_axis_tlast,  // word_end
    // Distance stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [7:0]                           o_m_axis_tdata,  // [7:0] distance
    // Configuration writes
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [bped_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [bped_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import bped_pkg::*;

    logic [QLET_W-1:0]    r_qletters;
    logic [QLEN_W-1:0]    r_qlen;
    t_bped_item           r_in;
    logic                 r_in_valid;
    logic [QUERY_MAX-1:0] r_vp;
    logic [QUERY_MAX-1:0] r_vn;
    t_bped_score          r_score;
    logic                 r_out_valid;
    logic [SCORE_W-1:0]   r_dist;

    logic [QUERY_MAX-1:0] n_vp;
    logic [QUERY_MAX-1:0] n_vn;
    t_bped_score          n_score;
    logic [SCORE_W-1:0]   n_dist;
    t_bped_item           in_item;
    logic                 out_free;
    logic                 proc;

    // Handshake: stage 2 moves when the result slot is free or draining
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign proc            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_dist;

    assign in_item.letter     = i_s_axis_tdata[LETTER_W-1:0];
    assign in_item.word_start = i_s_axis_tuser[0];
    assign in_item.word_end   = i_s_axis_tlast;
    assign in_item.empty_word = i_s_axis_tuser[1];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qletters <= '0;
            r_qlen     <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_QUERY_LETTERS: r_qletters <= i_cfg_wdata[QLET_W-1:0];
                CFG_QUERY_LENGTH:  r_qlen     <= i_cfg_wdata[QLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= in_item;
        end
    end

    // Recurrence step
    bped_step #(
        .QUERY_MAX     (QUERY_MAX),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_step (
        .i_item     (r_in),
        .i_qletters (r_qletters),
        .i_qlen     (r_qlen),
        .i_vp       (r_vp),
        .i_vn       (r_vn),
        .i_score    (r_score),
        .o_vp       (n_vp),
        .o_vn       (n_vn),
        .o_score    (n_score),
        .o_dist     (n_dist)
    );

    // Running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp    <= '1;
            r_vn    <= '0;
            r_score <= '0;
        end else if (proc) begin
            r_vp    <= n_vp;
            r_vn    <= n_vn;
            r_score <= n_score;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && r_in.word_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in.word_end) begin
            r_dist <= n_dist;
        end
    end

    // Checks
    `BPED_ASSERT_IMPLIES(a_sat_pins_score, i_clk, i_rst_n, r_score.sat, r_score.score == SCORE_MAX)
    `BPED_ASSERT_IMPLIES(a_deltas_disjoint, i_clk, i_rst_n, 1'b1, (r_vp & r_vn) == '0)
    `BPED_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, proc && r_in.word_end, r_out_valid)

endmodule

`default_nettype wire
